// ----- rtl/spn_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, S-box tables and bit functions for the 16-bit SPN cipher.
// No dependencies; used by spn_round_cell and spn_block_cipher_16bit.
package spn_pkg;

    localparam int NUM_ROUNDS = 4;

    // Operation codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // One item as it moves down the cell chain
    typedef struct packed {
        logic        op;
        logic [15:0] data;
    } item_t;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
    };

    localparam logic [3:0] SBOX_INV [16] = '{
        4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
        4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
    };

    // Round key r (1..5) is key bits [35-4r : 20-4r]
    function automatic logic [15:0] round_key(input logic [31:0] key, input int unsigned r);
        logic [31:0] shifted;
        shifted = key >> (20 - 4 * r);
        return shifted[15:0];
    endfunction

    function automatic logic [15:0] sub_fwd(input logic [15:0] x);
        logic [15:0] y;
        for (int n = 0; n < 4; n++)
        begin
            y[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
        end
        return y;
    endfunction

    function automatic logic [15:0] sub_inv(input logic [15:0] x);
        logic [15:0] y;
        for (int n = 0; n < 4; n++)
        begin
            y[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
        end
        return y;
    endfunction

    // Bit b of nibble n goes to bit n of nibble b (its own inverse)
    function automatic logic [15:0] transpose(input logic [15:0] x);
        logic [15:0] y;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                y[15 - (4*i + j)] = x[15 - (4*j + i)];
            end
        end
        return y;
    endfunction

endpackage

// ----- rtl/spn_round_cell.sv -----
`timescale 1ns / 1ps
// One round cell of the SPN pipeline: key xor, S-box layer, transpose.
// Depends on spn_pkg.
module spn_round_cell
    import spn_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] cipher_key,
    input  logic        up_valid,
    input  item_t       up_item,
    output logic        up_stall,
    output logic        dn_valid,
    output item_t       dn_item,
    input  logic        dn_stall
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  load;

    // Cell holds while its item waits on the next cell
    assign up_stall = valid_reg && dn_stall;
    assign load     = !up_stall;

    // Round function; decrypt mirrors the encrypt order
    always_comb
    begin
        logic [15:0] key_sel;
        logic [15:0] x;
        if (up_item.op == OP_DECRYPT)
            key_sel = round_key(cipher_key, 5 - STAGE);
        else
            key_sel = round_key(cipher_key, STAGE + 1);
        x = up_item.data ^ key_sel;
        if (up_item.op == OP_DECRYPT && STAGE > 0)
            x = transpose(x);
        if (up_item.op == OP_DECRYPT)
            x = sub_inv(x);
        else
            x = sub_fwd(x);
        if (up_item.op == OP_ENCRYPT && STAGE < NUM_ROUNDS - 1)
            x = transpose(x);
        item_next.op   = up_item.op;
        item_next.data = x;
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= up_valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load && up_valid)
            item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

`ifndef SYNTHESIS
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && dn_stall |=> valid_reg && $stable(item_reg))
        else $error("cell item changed while stalled");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        up_stall |-> valid_reg)
        else $error("cell stalls upstream while empty");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && !up_stall |=> valid_reg)
        else $error("accepted item lost in cell");
`endif

endmodule

// ----- rtl/spn_block_cipher_16bit.sv -----
`timescale 1ns / 1ps
// Top level of the 16-bit four-round SPN cipher: key register, chain of
// four spn_round_cell stages and a registered whitening output. Uses spn_pkg.
//
//  channel   signals                             direction
//  --------  ----------------------------------  ---------
//  req       req_valid, req_stall, operation,    in
//            block_in
//  rsp       rsp_valid, rsp_stall, block_out     out
//  key cfg   cipher_key_we, cipher_key_wdata     in
//
// One item per cycle sustained while rsp is not stalled; the path is four round
// cells plus the output register with the final key xor.
// Reset clears the key to zero and empties every cell; no clearing pass.
// A stall on rsp holds the output register and backs up cell by cell; empty
// cells keep taking items, so req_stall only rises once the chain is full.
module spn_block_cipher_16bit
    import spn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cipher_key_we,
    input  logic [31:0] cipher_key_wdata,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        operation,
    input  logic [15:0] block_in,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [15:0] block_out
);

    logic [31:0] cipher_key_reg;
    logic        cell_valid [NUM_ROUNDS+1];
    item_t       cell_item  [NUM_ROUNDS+1];
    logic        cell_stall [NUM_ROUNDS+1];
    logic        out_valid_reg;
    logic [15:0] block_out_reg;
    logic [15:0] block_out_next;
    logic        out_load;

    // Key register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cipher_key_reg <= 32'd0;
        else if (cipher_key_we)
            cipher_key_reg <= cipher_key_wdata;
    end

    // Head of the chain
    assign cell_valid[0]   = req_valid;
    assign cell_item[0].op   = operation;
    assign cell_item[0].data = block_in;
    assign req_stall       = cell_stall[0];

    // Round cells
    for (genvar s = 0; s < NUM_ROUNDS; s++)
    begin : g_cell
        spn_round_cell #(
            .STAGE (s)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cipher_key (cipher_key_reg),
            .up_valid   (cell_valid[s]),
            .up_item    (cell_item[s]),
            .up_stall   (cell_stall[s]),
            .dn_valid   (cell_valid[s+1]),
            .dn_item    (cell_item[s+1]),
            .dn_stall   (cell_stall[s+1])
        );
    end

    // Output stage: whitening xor, K5 for encrypt and K1 for decrypt
    assign cell_stall[NUM_ROUNDS] = out_valid_reg && rsp_stall;
    assign out_load               = !cell_stall[NUM_ROUNDS];

    always_comb
    begin
        if (cell_item[NUM_ROUNDS].op == OP_DECRYPT)
            block_out_next = cell_item[NUM_ROUNDS].data ^ round_key(cipher_key_reg, 1);
        else
            block_out_next = cell_item[NUM_ROUNDS].data ^ round_key(cipher_key_reg, 5);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= cell_valid[NUM_ROUNDS];
    end

    always_ff @(posedge clk)
    begin
        if (out_load && cell_valid[NUM_ROUNDS])
            block_out_reg <= block_out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign block_out = block_out_reg;

`ifndef SYNTHESIS
    a_no_stall_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !req_stall)
        else $error("input stalled while output register is free");

    a_out_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cell_valid[NUM_ROUNDS]))
        else $error("result appeared with no item in last cell");

    a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> cell_valid[1])
        else $error("accepted item did not enter first cell");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for spn_block_cipher_16bit: directed and random blocks in both
// directions under several keys, each result compared against an in-bench cipher model.
// Depends on spn_pkg and the RTL top level spn_block_cipher_16bit.
module testbench
    import spn_pkg::*;
();

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 12;
    localparam int PIPE_LATENCY    = 5;
    localparam int STUCK_LIMIT     = 400;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 194;
    localparam int MAX_PRINTED     = 100;

    localparam logic [3:0] SUB_FWD [16] = '{
        4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
    };
    localparam logic [3:0] SUB_INV [16] = '{
        4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
        4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
    };

    typedef struct packed {
        logic        op;
        logic [15:0] src;
        logic [15:0] result;
    } cipher_exp_t;

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        cipher_key_we    = 1'b0;
    logic [31:0] cipher_key_wdata = '0;
    logic        req_valid        = 1'b0;
    logic        req_stall;
    logic        operation        = OP_ENCRYPT;
    logic [15:0] block_in         = '0;
    logic        rsp_valid;
    logic        rsp_stall        = 1'b0;
    logic [15:0] block_out;

    item_t       block_queue[$];
    cipher_exp_t cipher_expected[$];
    cipher_exp_t got_rec;
    item_t       next_item;
    logic [31:0] key_model  = '0;
    int          idle_pct   = 0;
    int          send_gap   = 0;
    int          hold_left  = 0;
    int          stuck_cycles = 0;
    int          error_count  = 0;

    spn_block_cipher_16bit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cipher_key_we    (cipher_key_we),
        .cipher_key_wdata (cipher_key_wdata),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .operation        (operation),
        .block_in         (block_in),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .block_out        (block_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ---------------- cipher model ----------------

    // Round key r (1..5) sits at key bits [35-4r : 20-4r]
    function automatic logic [15:0] subkey(input logic [31:0] key, input int r);
        logic [31:0] shifted;
        shifted = key >> (20 - 4 * r);
        return shifted[15:0];
    endfunction

    function automatic logic [15:0] nibble_sub(input logic [15:0] x, input logic inverse);
        logic [15:0] y;
        for (int n = 0; n < 4; n++)
        begin
            y[4*n +: 4] = inverse ? SUB_INV[x[4*n +: 4]] : SUB_FWD[x[4*n +: 4]];
        end
        return y;
    endfunction

    // Nibble i bit j (both counted from the MSB) swaps with nibble j bit i
    function automatic logic [15:0] bit_transpose(input logic [15:0] x);
        logic [15:0] y;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                y[15 - 4*i - j] = x[15 - 4*j - i];
            end
        end
        return y;
    endfunction

    function automatic logic [15:0] cipher_block(input logic op, input logic [15:0] x,
                                                 input logic [31:0] key);
        logic [15:0] v;
        v = x;
        if (op == OP_ENCRYPT)
        begin
            for (int r = 1; r <= 3; r++)
            begin
                v = bit_transpose(nibble_sub(v ^ subkey(key, r), 1'b0));
            end
            v = nibble_sub(v ^ subkey(key, 4), 1'b0) ^ subkey(key, 5);
        end
        else
        begin
            v = nibble_sub(v ^ subkey(key, 5), 1'b1) ^ subkey(key, 4);
            for (int r = 3; r >= 1; r--)
            begin
                v = nibble_sub(bit_transpose(v), 1'b1) ^ subkey(key, r);
            end
        end
        return v;
    endfunction

    // ---------------- helpers ----------------

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
        begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic push_item(input logic op, input logic [15:0] blk);
        item_t it;
        it.op   = op;
        it.data = blk;
        block_queue.push_back(it);
    endtask

    // Key writes happen only with the pipe empty
    task automatic load_key(input logic [31:0] k);
        @(posedge clk);
        cipher_key_we    <= 1'b1;
        cipher_key_wdata <= k;
        @(posedge clk);
        cipher_key_we    <= 1'b0;
        key_model = k;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (block_queue.size() != 0 || req_valid || cipher_expected.size() != 0);
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    // ---------------- request driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_gap  <= 0;
        end
        else
        begin
            // item taken at this edge: record what must come out
            if (req_valid && !req_stall)
            begin
                cipher_expected.push_back('{operation, block_in,
                                           cipher_block(operation, block_in, key_model)});
            end
            // payload only moves once the current item is gone
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap  <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (block_queue.size() > 0)
                begin
                    next_item = block_queue.pop_front();
                    req_valid <= 1'b1;
                    operation <= next_item.op;
                    block_in  <= next_item.data;
                    if ($urandom_range(0, 99) < idle_pct)
                    begin
                        send_gap <= $urandom_range(1, 5);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- response monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (cipher_expected.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item, block_out %h", block_out));
                end
                else
                begin
                    got_rec = cipher_expected.pop_front();
                    if (block_out !== got_rec.result)
                    begin
                        report_mismatch($sformatf("%s %h key %h: block_out %h, want %h",
                            (got_rec.op == OP_DECRYPT) ? "decrypt" : "encrypt",
                            got_rec.src, key_model, block_out, got_rec.result));
                    end
                end
            end
            // random stall bursts on rsp
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                hold_left <= $urandom_range(0, 4);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if (rst_n && !(req_valid && !req_stall) && !(rsp_valid && !rsp_stall))
        begin
            stuck_cycles = stuck_cycles + 1;
        end
        else
        begin
            stuck_cycles = 0;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial
    begin
        logic [31:0]  k;
        logic [15:0]  blk;
        logic         op;
        int           n;
        int           sel;
        logic [15:0]  edge_blocks [4];

        edge_blocks = '{16'h0000, 16'hFFFF, 16'h8001, 16'h0F0F};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_pct = 25;

        // directed: extreme blocks both ways under the reset key, then the all-ones key
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
            begin
                load_key(32'hFFFF_FFFF);
            end
            foreach (edge_blocks[i])
            begin
                push_item(OP_ENCRYPT, edge_blocks[i]);
                push_item(OP_DECRYPT, edge_blocks[i]);
            end
            wait_idle();
        end

        // directed: encrypt then decrypt the ciphertext under a mixed key
        load_key(32'h1A2B_3C4D);
        for (int i = 0; i < 4; i++)
        begin
            blk = 16'($urandom);
            push_item(OP_ENCRYPT, blk);
            push_item(OP_DECRYPT, cipher_block(OP_ENCRYPT, blk, key_model));
        end
        wait_idle();

        // random phases, each under its own key; phases 1 and 4 and the last one run without idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       k = 32'h0000_0000;
                1:       k = 32'hFFFF_FFFF;
                2:       k = 32'h8000_0001;
                default: k = $urandom;
            endcase
            if (p == RANDOM_PHASES - 1 || p % 3 == 1)
            begin
                idle_pct = 0;
            end
            else
            begin
                idle_pct = (p % 2 == 0) ? 25 : 50;
            end
            load_key(k);
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                sel = $urandom_range(0, 9);
                blk = 16'($urandom);
                op  = 1'($urandom_range(0, 1));
                if (sel < 5)
                begin
                    // round trip: the second item undoes the first
                    push_item(op, blk);
                    push_item(~op, cipher_block(op, blk, key_model));
                    n += 2;
                end
                else if (sel < 9)
                begin
                    push_item(op, blk);
                    n++;
                end
                else
                begin
                    push_item(op, edge_blocks[2'($urandom_range(0, 3))]);
                    n++;
                end
            end
            wait_idle();
        end

        if (cipher_expected.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", cipher_expected.size()));
        end
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/spn_pkg.sv
rtl/spn_round_cell.sv
rtl/spn_block_cipher_16bit.sv
dv/testbench.sv
